FILE: rtl/lpd_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed message deframer.
//------------------------------------------------------------------------------
package lpd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned FieldW = 16;
	localparam int unsigned HdrW   = 24;

	localparam logic [FieldW-1:0] MaxLengthReset = 16'd2048;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_HALTED = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BODY    = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_BAD_ID  = 2'd2,
		KIND_BAD_LEN = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [FieldW-1:0] msg_id;
		logic [ByteW-1:0]  body_byte;
		logic              last;
	} result_t;

endpackage

FILE: rtl/length_prefixed_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// length_prefixed_deframer
// Splits a byte stream into messages with a 4-byte id/length header.
//------------------------------------------------------------------------------
// Usage:
//   s_axis carries one stream byte per transfer in tdata[7:0].
//   m_axis carries results: tdata holds msg_id[15:0] and body_byte[23:16],
//   tuser the kind (body byte, empty message, bad id, bad length), tlast the
//   final byte of a body or empty message. Only header byte 4 can give a result.
//   cfg_we/cfg_wdata write the length limit (reset 2048); write only while idle.
//   Path: a byte's transfer loads the input register; its parse outcome, if
//   any, enters the result register when that register moves or is empty.
//   Throughput: one byte per cycle while the receiver does not stall.
//   A stalled receiver holds the result register; the input register still
//   takes a byte while it is empty or the result register moves or is empty.
//   Reset clears the parser to header phase and empties both registers;
//   after an error result all bytes are dropped until reset.
//------------------------------------------------------------------------------
module length_prefixed_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [23:0] m_axis_tdata,   // msg_id[15:0], body_byte[23:16]
	output      logic [1:0]  m_axis_tuser,   // kind[1:0]
	output      logic        m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic                         valid_s1;
	logic [lpd_pkg::ByteW-1:0]    byte_s1;
	logic [lpd_pkg::FieldW-1:0]   len_limit_q;
	logic                         advance;
	logic                         res_valid;
	lpd_pkg::result_t             res;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit_q <= lpd_pkg::MaxLengthReset;
		end else if (cfg_we) begin
			len_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	lpd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.data_byte  (byte_s1),
		.len_limit  (len_limit_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	lpd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.res_valid     (res_valid),
		.res           (res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

FILE: rtl/lpd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// lpd_parser
// Header collection, limit checks and body counting; one byte per step.
//------------------------------------------------------------------------------
module lpd_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [lpd_pkg::ByteW-1:0]      data_byte,
	input  wire logic [lpd_pkg::FieldW-1:0]     len_limit,
	output      logic                           res_valid,
	output      lpd_pkg::result_t               res
);

	lpd_pkg::phase_t                 phase_q, phase_n;
	logic [1:0]                      count_q, count_n;
	logic [lpd_pkg::HdrW-1:0]        store_q, store_n;
	logic [lpd_pkg::FieldW-1:0]      id_q, id_n;
	logic [lpd_pkg::FieldW-1:0]      remaining_q, remaining_n;

	logic [lpd_pkg::FieldW-1:0]      hdr_id;
	logic [lpd_pkg::FieldW-1:0]      hdr_len;
	logic                            hdr_done;
	logic                            body_end;

	assign hdr_id   = store_q[lpd_pkg::HdrW-1:lpd_pkg::ByteW];
	assign hdr_len  = {store_q[lpd_pkg::ByteW-1:0], data_byte};
	assign hdr_done = (count_q == 2'd3);
	assign body_end = (remaining_q == lpd_pkg::FieldW'(1));

	always_comb begin
		phase_n     = phase_q;
		count_n     = count_q;
		store_n     = store_q;
		id_n        = id_q;
		remaining_n = remaining_q;
		if (step) begin
			unique case (phase_q)
				lpd_pkg::PH_HEADER: begin
					if (!hdr_done) begin
						store_n = {store_q[lpd_pkg::HdrW-lpd_pkg::ByteW-1:0], data_byte};
						count_n = count_q + 2'd1;
					end else begin
						store_n = '0;
						count_n = '0;
						if ((hdr_id > len_limit) || (hdr_len > len_limit)) begin
							phase_n = lpd_pkg::PH_HALTED;
						end else if (hdr_len != '0) begin
							id_n        = hdr_id;
							remaining_n = hdr_len;
							phase_n     = lpd_pkg::PH_BODY;
						end
					end
				end
				lpd_pkg::PH_BODY: begin
					remaining_n = remaining_q - lpd_pkg::FieldW'(1);
					if (body_end) begin
						phase_n = lpd_pkg::PH_HEADER;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		res_valid     = 1'b0;
		res.kind      = lpd_pkg::KIND_BODY;
		res.msg_id    = hdr_id;
		res.body_byte = '0;
		res.last      = 1'b0;
		if (step) begin
			unique case (phase_q)
				lpd_pkg::PH_HEADER: begin
					if (hdr_done) begin
						priority if (hdr_id > len_limit) begin
							res_valid = 1'b1;
							res.kind  = lpd_pkg::KIND_BAD_ID;
						end else if (hdr_len > len_limit) begin
							res_valid = 1'b1;
							res.kind  = lpd_pkg::KIND_BAD_LEN;
						end else if (hdr_len == '0) begin
							res_valid = 1'b1;
							res.kind  = lpd_pkg::KIND_EMPTY;
							res.last  = 1'b1;
						end else begin
							res_valid = 1'b0;
						end
					end
				end
				lpd_pkg::PH_BODY: begin
					res_valid     = 1'b1;
					res.kind      = lpd_pkg::KIND_BODY;
					res.msg_id    = id_q;
					res.body_byte = data_byte;
					res.last      = body_end;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lpd_pkg::PH_HEADER;
			count_q     <= '0;
			store_q     <= '0;
			id_q        <= '0;
			remaining_q <= '0;
		end else begin
			phase_q     <= phase_n;
			count_q     <= count_n;
			store_q     <= store_n;
			id_q        <= id_n;
			remaining_q <= remaining_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/lpd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// lpd_out_reg
// Result register driving the master stream; holds a result until taken.
//------------------------------------------------------------------------------
module lpd_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             res_valid,
	input  wire lpd_pkg::result_t res,
	output      logic             m_axis_tvalid,
	output      logic [23:0]      m_axis_tdata,  // msg_id[15:0], body_byte[23:16]
	output      logic [1:0]       m_axis_tuser,  // kind[1:0]
	output      logic             m_axis_tlast
);

	logic             valid_s2;
	lpd_pkg::result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.body_byte, res_s2.msg_id};
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = res_s2.last;

endmodule
`default_nettype wire
